@@ src/falling_glyph_column_animator_unit_defines.svh @@
// Assertion macros used by the checker file of the glyph column animator.
`ifndef FALLING_GLYPH_COLUMN_ANIMATOR_UNIT_DEFINES_SVH
`define FALLING_GLYPH_COLUMN_ANIMATOR_UNIT_DEFINES_SVH

// Clocked assertion, disabled while the reset is asserted.
`define FGCA_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Same, on the default clock and reset names.
`define FGCA_ASSERT(lbl, prop, msg) \
	`FGCA_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

@@ src/fgca_pkg.sv @@
// Shared types, constants and functions of the glyph column animator.
package fgca_pkg;

	localparam int MASK_W        = 16;
	localparam int SPAWN_LANES   = 16;
	localparam int LAYER_W       = 8;
	localparam int COLUMN_W      = 4;
	localparam int POS_W         = 6;
	localparam int GLYPH_W       = 6;
	localparam int COLOUR_W      = 3;
	localparam int SPEED_W       = 2;
	localparam int TICK_W        = 2;
	localparam int RAND_W        = 32;
	localparam int GLYPH_COUNT   = 45;
	localparam int REDRAW_PERIOD = 3;
	localparam int SPEED_MOD     = 3;

	localparam logic [RAND_W-1:0] SEED_DEFAULT = 32'hDEAD_BEEF;

	localparam int XS_SHIFT_A = 13;
	localparam int XS_SHIFT_B = 17;
	localparam int XS_SHIFT_C = 5;

	typedef logic [SPEED_W-1:0] speed_lut_t [GLYPH_COUNT];

	// One xorshift32 generator step.
	function automatic logic [RAND_W-1:0] xorshift32(input logic [RAND_W-1:0] s);
		logic [RAND_W-1:0] x;
		x = s ^ (s << XS_SHIFT_A);
		x = x ^ (x >> XS_SHIFT_B);
		x = x ^ (x << XS_SHIFT_C);
		return x;
	endfunction

	// Speed 1 + (r mod 3) from r mod 45; 3 divides 45, so the residue is enough.
	function automatic speed_lut_t speed_lut_init();
		speed_lut_t lut;
		int k;
		k = 0;
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			lut[i] = SPEED_W'(k + 1);
			k = (k == SPEED_MOD - 1) ? 0 : k + 1;
		end
		return lut;
	endfunction

	localparam speed_lut_t SPEED_LUT = speed_lut_init();

endpackage

@@ src/fgca_ifs.sv @@
// Handshake channel interfaces for animation ticks and per-column results.
interface fgca_tick_if import fgca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  spawn_mask;
	logic [LAYER_W-1:0] active_layer;

	modport source(output valid, spawn_mask, active_layer, input ready);
	modport sink(input valid, spawn_mask, active_layer, output ready);
endinterface

interface fgca_result_if import fgca_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLUMN_W-1:0] column;
	logic                head_visible;
	logic [POS_W-1:0]    head_y;
	logic [GLYPH_W-1:0]  head_glyph;
	logic                trail_visible;
	logic [POS_W-1:0]    trail_y;
	logic [GLYPH_W-1:0]  trail_glyph;
	logic [COLOUR_W-1:0] colour_index;
	logic                last;

	modport source(output valid, column, head_visible, head_y, head_glyph, trail_visible,
		trail_y, trail_glyph, colour_index, last, input ready);
	modport sink(input valid, column, head_visible, head_y, head_glyph, trail_visible,
		trail_y, trail_glyph, colour_index, last, output ready);
endinterface

@@ src/fgca_mod_unit.sv @@
// Pipelined residue unit: 32-bit value modulo the glyph count; done marks the registered result.
module fgca_mod_unit import fgca_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAND_W-1:0]  value,
	output logic               done,
	output logic [GLYPH_W-1:0] result
);

	// 4096 leaves remainder 1 modulo 45, so the 12-bit chunks of the value simply add up.
	localparam int FOLD_W      = 12;
	localparam int SUM_W       = 14;
	localparam int QUO_W       = 8;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = RECIP_SHIFT + QUO_W;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(23302);

	logic [SUM_W-1:0]   fold_sum;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   rem_full;
	logic [SUM_W-1:0]   sum_s1;
	logic [SUM_W-1:0]   sum_s2;
	logic [QUO_W-1:0]   quo_s2;
	logic [GLYPH_W-1:0] rem_q;
	logic               vld_s1;
	logic               vld_s2;
	logic               done_q;

	assign fold_sum = SUM_W'(value[FOLD_W-1:0]) + SUM_W'(value[2*FOLD_W-1:FOLD_W])
		+ SUM_W'(value[RAND_W-1:2*FOLD_W]);

	// Quotient by 45 as (s * ceil(2^20 / 45)) >> 20, exact over the whole folded range.
	assign prod     = PROD_W'(sum_s1) * RECIP;
	assign rem_full = sum_s2 - SUM_W'(quo_s2) * SUM_W'(GLYPH_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Fold, then quotient, then remainder.
	always_ff @(posedge clk) begin
		sum_s1 <= fold_sum;
		sum_s2 <= sum_s1;
		quo_s2 <= prod[PROD_W-1 -: QUO_W];
		rem_q  <= rem_full[GLYPH_W-1:0];
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule

@@ src/fgca_col_ram.sv @@
// Per-column state memory: one write and one registered read port, zero until written.
module fgca_col_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
		end
	end

	// An entry never written reads as all zero: inactive column.
	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

@@ src/falling_glyph_column_animator_unit.sv @@
// Falling glyph column animator. One tick transaction on the tick channel runs a
// spawn pass and then a fall pass over COLUMN_COUNT columns, and yields exactly
// COLUMN_COUNT result transactions in ascending column order, the final one marked
// with last. Per-column state lives in a single-port-read, single-port-write memory
// with a registered read; each column is read, modified and written back in turn, so
// the two passes never touch one entry in overlapping cycles. All random draws come
// from one shared xorshift32 generator feeding a three-stage modulo-45 unit (chunk
// fold, reciprocal multiply, subtract). In the spawn pass each column goes through a
// read and a check state, in the fall pass through a read, a calculate and an output
// state, and each generator draw adds a wait on the modulo unit; a spawning column
// draws twice, a column whose head glyph is redrawn draws once. A waiting result
// stalls the fall pass only; the next tick is taken as soon as the last result of the
// current tick sits in the output register. Writing prng_seed reloads the generator
// at once (zero loads 0xDEADBEEF); write it only between ticks. After reset every
// column is idle.
module falling_glyph_column_animator_unit import fgca_pkg::*; #(
	parameter int COLUMN_COUNT = 16,
	parameter int ZONE_HEIGHT  = 55,
	parameter int TRAIL_OFFSET = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prng_seed_we,
	input  logic [RAND_W-1:0]  prng_seed,
	fgca_tick_if.sink          tick,
	fgca_result_if.source      result
);

	localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
	localparam int HGT_W = $clog2(ZONE_HEIGHT + 3);
	localparam int CMP_W = (HGT_W > 7) ? HGT_W : 7;

	// Column record as stored in the memory.
	typedef struct packed {
		logic [HGT_W-1:0]    height;
		logic [SPEED_W-1:0]  speed;
		logic [TICK_W-1:0]   glyph_tick;
		logic                active;
		logic                trail;
		logic [GLYPH_W-1:0]  head_sym;
		logic [GLYPH_W-1:0]  trail_sym;
		logic [COLOUR_W-1:0] colour;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SP_RD   = 9'b000000010,
		S_SP_CHK  = 9'b000000100,
		S_SP_SPD  = 9'b000001000,
		S_SP_GLY  = 9'b000010000,
		S_FL_RD   = 9'b000100000,
		S_FL_CALC = 9'b001000000,
		S_FL_GLY  = 9'b010000000,
		S_FL_OUT  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [COL_W-1:0]     col_q;
	logic [MASK_W-1:0]    mask_q;
	logic [COLOUR_W-1:0]  colour_q;
	logic [RAND_W-1:0]    gen_q;
	entry_t               ent_q;

	logic                 res_valid_q;
	logic [COLUMN_W-1:0]  res_column_q;
	logic                 res_head_vis_q;
	logic [POS_W-1:0]     res_head_y_q;
	logic [GLYPH_W-1:0]   res_head_glyph_q;
	logic                 res_trail_vis_q;
	logic [POS_W-1:0]     res_trail_y_q;
	logic [GLYPH_W-1:0]   res_trail_glyph_q;
	logic [COLOUR_W-1:0]  res_colour_q;
	logic                 res_last_q;

	logic [ENTRY_W-1:0]   ram_rdata;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic                 ram_we;
	entry_t               rd_ent;
	entry_t               spawn_ent;
	entry_t               fall_ent;
	entry_t               fin_ent;

	logic [RAND_W-1:0]    gen_next;
	logic                 mod_start;
	logic                 mod_done;
	logic [GLYPH_W-1:0]   mod_result;

	logic                 col_last;
	logic                 spawn_req;
	logic                 redraw;
	logic                 out_free;
	logic [CMP_W-1:0]     hgt_ext;
	logic [CMP_W-1:0]     trail_pos;

	fgca_col_ram #(
		.DEPTH  (COLUMN_COUNT),
		.ADDR_W (COL_W),
		.DATA_W (ENTRY_W)
	) u_col_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (col_q),
		.wdata  (ram_wdata),
		.raddr  (col_q),
		.rdata  (ram_rdata)
	);

	fgca_mod_unit u_mod_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (gen_next),
		.done   (mod_done),
		.result (mod_result)
	);

	assign rd_ent   = ram_rdata;
	assign gen_next = xorshift32(gen_q);
	assign col_last = (col_q == COL_W'(COLUMN_COUNT - 1));
	assign out_free = !res_valid_q || result.ready;

	// Only the low 16 columns have a spawn request bit.
	assign spawn_req = (CMP_W'(col_q) < CMP_W'(SPAWN_LANES)) && mask_q[COLUMN_W'(col_q)]
		&& !rd_ent.active;

	// Head glyph is due for a redraw on every third step of the count.
	assign redraw = (rd_ent.glyph_tick + 1'b1) == TICK_W'(REDRAW_PERIOD);

	// Fresh drop: speed drawn first, then the glyph shared by head and trail.
	always_comb begin
		spawn_ent            = '0;
		spawn_ent.speed      = ent_q.speed;
		spawn_ent.active     = 1'b1;
		spawn_ent.head_sym   = mod_result;
		spawn_ent.trail_sym  = mod_result;
		spawn_ent.colour     = colour_q;
	end

	// Advance an active drop by its speed and step the glyph count.
	always_comb begin
		fall_ent        = rd_ent;
		fall_ent.height = rd_ent.height + HGT_W'(rd_ent.speed);
		fall_ent.glyph_tick = redraw ? '0 : rd_ent.glyph_tick + 1'b1;
	end

	// Trail shows once the head reaches the offset; the drop stops at the zone floor.
	always_comb begin
		hgt_ext   = CMP_W'(ent_q.height);
		trail_pos = hgt_ext - CMP_W'(TRAIL_OFFSET);
		fin_ent   = ent_q;
		if (hgt_ext >= CMP_W'(TRAIL_OFFSET)) begin
			fin_ent.trail = 1'b1;
		end
		if (hgt_ext >= CMP_W'(ZONE_HEIGHT)) begin
			fin_ent.active = 1'b0;
			fin_ent.trail  = 1'b0;
		end
	end

	always_comb begin
		mod_start = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = fin_ent;
		case (state_q)
			S_SP_CHK: begin
				mod_start = spawn_req;
			end
			S_SP_SPD: begin
				mod_start = mod_done;
			end
			S_SP_GLY: begin
				ram_we    = mod_done;
				ram_wdata = spawn_ent;
			end
			S_FL_CALC: begin
				mod_start = rd_ent.active && redraw;
			end
			S_FL_OUT: begin
				ram_we = out_free && ent_q.active;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			gen_q   <= SEED_DEFAULT;
		end else begin
			if (mod_start) begin
				gen_q <= gen_next;
			end
			case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						col_q   <= '0;
						state_q <= S_SP_RD;
					end
				end
				S_SP_RD: begin
					state_q <= S_SP_CHK;
				end
				S_SP_CHK: begin
					if (spawn_req) begin
						state_q <= S_SP_SPD;
					end else if (col_last) begin
						col_q   <= '0;
						state_q <= S_FL_RD;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_SP_RD;
					end
				end
				S_SP_SPD: begin
					if (mod_done) begin
						state_q <= S_SP_GLY;
					end
				end
				S_SP_GLY: begin
					if (mod_done) begin
						if (col_last) begin
							col_q   <= '0;
							state_q <= S_FL_RD;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_SP_RD;
						end
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_CALC;
				end
				S_FL_CALC: begin
					state_q <= (rd_ent.active && redraw) ? S_FL_GLY : S_FL_OUT;
				end
				S_FL_GLY: begin
					if (mod_done) begin
						state_q <= S_FL_OUT;
					end
				end
				S_FL_OUT: begin
					if (out_free) begin
						if (col_last) begin
							col_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_FL_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Seed reload: zero maps to the default seed.
			if (prng_seed_we) begin
				gen_q <= (prng_seed == '0) ? SEED_DEFAULT : prng_seed;
			end
		end
	end

	// Tick fields and the working column record.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && tick.valid) begin
			mask_q   <= tick.spawn_mask;
			colour_q <= tick.active_layer[COLOUR_W-1:0];
		end
		if (state_q == S_SP_SPD && mod_done) begin
			ent_q.speed <= SPEED_LUT[mod_result];
		end
		if (state_q == S_FL_CALC) begin
			ent_q <= rd_ent.active ? fall_ent : rd_ent;
		end
		if (state_q == S_FL_GLY && mod_done) begin
			ent_q.head_sym <= mod_result;
		end
	end

	// Output register: hold a result until taken, load the next in the fall pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FL_OUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FL_OUT && out_free) begin
			res_column_q      <= COLUMN_W'(col_q);
			res_last_q        <= col_last;
			res_head_vis_q    <= fin_ent.active;
			res_head_y_q      <= fin_ent.active ? POS_W'(ent_q.height) : '0;
			res_head_glyph_q  <= fin_ent.active ? ent_q.head_sym : '0;
			res_trail_vis_q   <= fin_ent.active && fin_ent.trail;
			res_trail_y_q     <= (fin_ent.active && fin_ent.trail) ? trail_pos[POS_W-1:0] : '0;
			res_trail_glyph_q <= fin_ent.active ? ent_q.trail_sym : '0;
			res_colour_q      <= fin_ent.active ? ent_q.colour : '0;
		end
	end

	assign tick.ready           = (state_q == S_IDLE);
	assign result.valid         = res_valid_q;
	assign result.column        = res_column_q;
	assign result.head_visible  = res_head_vis_q;
	assign result.head_y        = res_head_y_q;
	assign result.head_glyph    = res_head_glyph_q;
	assign result.trail_visible = res_trail_vis_q;
	assign result.trail_y       = res_trail_y_q;
	assign result.trail_glyph   = res_trail_glyph_q;
	assign result.colour_index  = res_colour_q;
	assign result.last          = res_last_q;

endmodule

@@ src/fgca_checker.sv @@
// Port-level checker for the glyph column animator, bound to the top level.
`include "falling_glyph_column_animator_unit_defines.svh"

module fgca_checker import fgca_pkg::*; #(
	parameter int COLUMN_COUNT = 16,
	parameter int TRAIL_OFFSET = 20
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [COLUMN_W-1:0] column,
	input logic                head_visible,
	input logic [POS_W-1:0]    head_y,
	input logic [GLYPH_W-1:0]  head_glyph,
	input logic                trail_visible,
	input logic [POS_W-1:0]    trail_y,
	input logic [GLYPH_W-1:0]  trail_glyph,
	input logic [COLOUR_W-1:0] colour_index,
	input logic                last
);

	localparam int IDX_W = $clog2(COLUMN_COUNT + 1);
	localparam logic [POS_W-1:0] TRAIL_Y6 = POS_W'(TRAIL_OFFSET);

	logic             in_acc;
	logic             out_acc;
	logic [IDX_W-1:0] exp_idx_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track the column expected next on the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_acc) begin
			exp_idx_q <= last ? '0 : exp_idx_q + 1'b1;
		end
	end

	`FGCA_ASSERT(a_column_order, out_valid |-> (column == COLUMN_W'(exp_idx_q)) && (last == (exp_idx_q == IDX_W'(COLUMN_COUNT - 1))), "results out of column order or last misplaced")
	`FGCA_ASSERT(a_tick_boundary, in_acc |-> (exp_idx_q == '0) || (out_valid && last), "tick taken while results of the previous tick are outstanding")
	`FGCA_ASSERT(a_idle_zero, (out_valid && !head_visible) |-> !trail_visible && (head_y == '0) && (head_glyph == '0) && (trail_y == '0) && (trail_glyph == '0) && (colour_index == '0), "inactive column shows nonzero fields")
	`FGCA_ASSERT(a_trail_pos, (out_valid && trail_visible) |-> head_visible && (trail_y == POS_W'(head_y - TRAIL_Y6)), "trail not at fixed offset behind head")
	`FGCA_ASSERT(a_result_hold, (out_valid && !out_ready) |=> out_valid && $stable(column) && $stable(head_y) && $stable(trail_y), "stalled result changed")

endmodule

bind falling_glyph_column_animator_unit fgca_checker #(
	.COLUMN_COUNT (COLUMN_COUNT),
	.TRAIL_OFFSET (TRAIL_OFFSET)
) u_fgca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (tick.valid),
	.in_ready      (tick.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.column        (result.column),
	.head_visible  (result.head_visible),
	.head_y        (result.head_y),
	.head_glyph    (result.head_glyph),
	.trail_visible (result.trail_visible),
	.trail_y       (result.trail_y),
	.trail_glyph   (result.trail_glyph),
	.colour_index  (result.colour_index),
	.last          (result.last)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the falling glyph column animator: directed and random ticks.
module tb_top;
	import fgca_pkg::*;

	localparam int COLUMNS            = 16;
	localparam int ZONE_H             = 55;
	localparam int TRAIL_OFS          = 20;
	localparam int IDLE_PCT           = 12;
	localparam int RESET_CYCLES       = 6;
	localparam int SETTLE_CYCLES      = 20;
	localparam int RANDOM_PHASE_TICKS = 77;
	// A tick where every column spawns runs its whole spawn pass before its first result.
	// The limit is many times that wait, plus room for sender gaps and receiver stalls.
	localparam int WATCHDOG_LIMIT     = 4000;

	// One expected per-column result, laid out like the result channel.
	typedef struct {
		logic [COLUMN_W-1:0] column;
		logic                head_visible;
		logic [POS_W-1:0]    head_y;
		logic [GLYPH_W-1:0]  head_glyph;
		logic                trail_visible;
		logic [POS_W-1:0]    trail_y;
		logic [GLYPH_W-1:0]  trail_glyph;
		logic [COLOUR_W-1:0] colour_index;
		logic                last;
	} column_view_t;

	logic              clk;
	logic              arst_n;
	logic              prng_seed_we;
	logic [RAND_W-1:0] prng_seed;

	fgca_tick_if   tick_ch();
	fgca_result_if result_ch();

	falling_glyph_column_animator_unit #(
		.COLUMN_COUNT(COLUMNS),
		.ZONE_HEIGHT (ZONE_H),
		.TRAIL_OFFSET(TRAIL_OFS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.prng_seed_we(prng_seed_we),
		.prng_seed   (prng_seed),
		.tick        (tick_ch),
		.result      (result_ch)
	);

	// Predicted column state, kept in step with every accepted tick transaction.
	logic [RAND_W-1:0]   rng_state;
	logic [POS_W-1:0]    drop_height  [COLUMNS];
	logic [SPEED_W-1:0]  drop_speed   [COLUMNS];
	logic [TICK_W-1:0]   redraw_count [COLUMNS];
	logic                drop_active  [COLUMNS];
	logic                trail_on     [COLUMNS];
	logic [GLYPH_W-1:0]  head_sym     [COLUMNS];
	logic [GLYPH_W-1:0]  trail_sym    [COLUMNS];
	logic [COLOUR_W-1:0] drop_colour  [COLUMNS];

	// Results still owed by the block, oldest first.
	column_view_t pending_views[$];

	int  mismatches      = 0;
	int  ticks_sent      = 0;
	int  results_checked = 0;
	int  drops_spawned   = 0;
	int  drops_landed    = 0;
	int  quiet_cycles    = 0;
	// While calm is set neither side inserts idle cycles.
	bit  calm            = 1'b0;

	// Clock: 4 units high, 4 units low.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Step the shared xorshift32 generator and return the new state.
	function automatic logic [RAND_W-1:0] next_draw();
		logic [RAND_W-1:0] x;
		x = rng_state;
		x = x ^ (x << XS_SHIFT_A);
		x = x ^ (x >> XS_SHIFT_B);
		x = x ^ (x << XS_SHIFT_C);
		rng_state = x;
		return x;
	endfunction

	// Run one tick on the predicted state: spawn pass, then fall pass, queuing one
	// expected result per column.
	task automatic advance_columns(input logic [MASK_W-1:0] mask,
			input logic [LAYER_W-1:0] layer);
		column_view_t v;
		// Spawn pass: only idle columns take a request; each spawn draws speed, then glyph.
		for (int c = 0; c < COLUMNS; c++) begin
			if (mask[c] && !drop_active[c]) begin
				drop_height[c]  = '0;
				drop_speed[c]   = SPEED_W'(1 + next_draw() % 32'(SPEED_MOD));
				redraw_count[c] = '0;
				drop_active[c]  = 1'b1;
				trail_on[c]     = 1'b0;
				head_sym[c]     = GLYPH_W'(next_draw() % 32'(GLYPH_COUNT));
				trail_sym[c]    = head_sym[c];
				drop_colour[c]  = layer[COLOUR_W-1:0];
				drops_spawned++;
			end
		end
		// Fall pass: a column spawned above falls in this same tick.
		for (int c = 0; c < COLUMNS; c++) begin
			if (drop_active[c]) begin
				drop_height[c]  = drop_height[c] + POS_W'(drop_speed[c]);
				redraw_count[c] = redraw_count[c] + 1'b1;
				if (redraw_count[c] >= REDRAW_PERIOD) begin
					redraw_count[c] = '0;
					head_sym[c]     = GLYPH_W'(next_draw() % 32'(GLYPH_COUNT));
				end
				if (drop_height[c] >= TRAIL_OFS) begin
					trail_on[c] = 1'b1;
				end
				if (drop_height[c] >= ZONE_H) begin
					drop_active[c] = 1'b0;
					trail_on[c]    = 1'b0;
					drops_landed++;
				end
			end
			v.column = COLUMN_W'(c);
			v.last   = (c == COLUMNS - 1);
			if (drop_active[c]) begin
				v.head_visible  = 1'b1;
				v.head_y        = drop_height[c];
				v.head_glyph    = head_sym[c];
				v.trail_visible = trail_on[c];
				v.trail_y       = trail_on[c] ? POS_W'(drop_height[c] - TRAIL_OFS) : '0;
				v.trail_glyph   = trail_sym[c];
				v.colour_index  = drop_colour[c];
			end else begin
				// Idle or just landed: everything but the column number reads zero.
				v.head_visible  = 1'b0;
				v.head_y        = '0;
				v.head_glyph    = '0;
				v.trail_visible = 1'b0;
				v.trail_y       = '0;
				v.trail_glyph   = '0;
				v.colour_index  = '0;
			end
			pending_views.push_back(v);
		end
	endtask

	task automatic clear_columns();
		rng_state = SEED_DEFAULT;
		for (int c = 0; c < COLUMNS; c++) begin
			drop_height[c]  = '0;
			drop_speed[c]   = '0;
			redraw_count[c] = '0;
			drop_active[c]  = 1'b0;
			trail_on[c]     = 1'b0;
			head_sym[c]     = '0;
			trail_sym[c]    = '0;
			drop_colour[c]  = '0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int col,
			input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("column %0d %s: got %0d, expected %0d",
				col, name, got, want));
		end
	endtask

	// Check one accepted result transaction against the oldest expectation.
	task automatic check_view();
		column_view_t want;
		int           col;
		results_checked++;
		if (pending_views.size() == 0) begin
			report_mismatch($sformatf("result for column %0d with nothing pending",
				result_ch.column));
			return;
		end
		want = pending_views.pop_front();
		col  = int'(want.column);
		compare_field("column", col, 8'(result_ch.column), 8'(want.column));
		compare_field("head_visible", col, 8'(result_ch.head_visible), 8'(want.head_visible));
		compare_field("head_y", col, 8'(result_ch.head_y), 8'(want.head_y));
		compare_field("head_glyph", col, 8'(result_ch.head_glyph), 8'(want.head_glyph));
		compare_field("trail_visible", col, 8'(result_ch.trail_visible),
			8'(want.trail_visible));
		compare_field("trail_y", col, 8'(result_ch.trail_y), 8'(want.trail_y));
		compare_field("trail_glyph", col, 8'(result_ch.trail_glyph), 8'(want.trail_glyph));
		compare_field("colour_index", col, 8'(result_ch.colour_index), 8'(want.colour_index));
		compare_field("last", col, 8'(result_ch.last), 8'(want.last));
	endtask

	// Result side: check on every handshake, then pick ready for the next edge.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			check_view();
		end
		result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog: count edges where neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", quiet_cycles);
				$display("falling_glyph_column_animator_unit: mismatch");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Send one tick; valid stays high afterwards so the next tick can follow back to back.
	task automatic send_tick(input logic [MASK_W-1:0] mask, input logic [LAYER_W-1:0] layer);
		// Drop valid for a random number of cycles unless the run is calm.
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.spawn_mask   <= mask;
		tick_ch.active_layer <= layer;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		advance_columns(mask, layer);
		ticks_sent++;
	endtask

	// Drop valid and hold until every owed result has come back.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_views.size() != 0);
	endtask

	// Write the seed register; the generator reloads at once, zero maps to the default.
	task automatic load_seed(input logic [RAND_W-1:0] value);
		prng_seed_we <= 1'b1;
		prng_seed    <= value;
		@(posedge clk);
		prng_seed_we <= 1'b0;
		rng_state = (value == '0) ? SEED_DEFAULT : value;
	endtask

	// Mostly sparse spawn requests so drops live long enough to fall, trail and land.
	function automatic logic [MASK_W-1:0] pick_mask();
		int                sel;
		logic [MASK_W-1:0] m;
		sel = $urandom_range(99);
		m   = '0;
		if (sel < 55) begin
			for (int b = 0; b < MASK_W; b++) begin
				m[b] = ($urandom_range(7) == 0);
			end
		end else if (sel < 75) begin
			m[$urandom_range(MASK_W - 1)] = 1'b1;
		end else if (sel < 88) begin
			m = MASK_W'($urandom);
		end else if (sel < 94) begin
			m = '0;
		end else begin
			m = '1;
		end
		return m;
	endfunction

	// Nothing spawned yet: every column reads idle, on the reset seed.
	task automatic test_idle_after_reset();
		send_tick(16'h0000, 8'h00);
		send_tick(16'h0000, 8'hFF);
	endtask

	// Spawn every column at the top layer, then ask again while all are busy.
	task automatic test_full_spawn();
		send_tick(16'hFFFF, 8'hFF);
		send_tick(16'hFFFF, 8'h00);
		send_tick(16'h8000, 8'h0F);
		send_tick(16'h0001, 8'hF0);
	endtask

	// Let the drops fall: trails appear, fast drops land, then respawn the landed ones.
	task automatic test_fall_and_trail();
		for (int i = 0; i < 16; i++) begin
			send_tick(16'h0000, LAYER_W'(1 << (i % LAYER_W)));
		end
		send_tick(16'hFFFF, 8'hAA);
		settle();
	endtask

	// One random phase on a given seed, with a full drain halfway through.
	task automatic test_random_phase(input logic [RAND_W-1:0] seed, input bit quiet);
		settle();
		load_seed(seed);
		calm = quiet;
		for (int i = 0; i < RANDOM_PHASE_TICKS; i++) begin
			if (i == RANDOM_PHASE_TICKS / 2) begin
				settle();
			end
			send_tick(pick_mask(), LAYER_W'($urandom_range(255)));
		end
		settle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		prng_seed_we         <= 1'b0;
		prng_seed            <= '0;
		tick_ch.valid        <= 1'b0;
		tick_ch.spawn_mask   <= '0;
		tick_ch.active_layer <= '0;
		clear_columns();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_full_spawn();
		test_fall_and_trail();
		// Seed extremes: zero (maps to default), all ones, one, then a random seed.
		test_random_phase(32'h0000_0000, 1'b0);
		test_random_phase(32'hFFFF_FFFF, 1'b1);
		test_random_phase(32'h0000_0001, 1'b0);
		test_random_phase(RAND_W'($urandom), 1'b0);

		// Give the block time to show any stray result.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d ticks sent, %0d column results checked, %0d mismatches",
			ticks_sent, results_checked, mismatches);
		$display("%0d drops spawned and %0d landed over reset, zero, one, all-ones and random seeds",
			drops_spawned, drops_landed);
		if (mismatches == 0) begin
			$display("falling_glyph_column_animator_unit: match");
		end else begin
			$display("falling_glyph_column_animator_unit: mismatch");
		end
		$finish;
	end

endmodule
